// ===== rtl/core/mrwp_pkg.sv =====
// Shared types and constants for the mixed radix word packer.
package mrwp_pkg;

    localparam int WORD_W        = 64;
    localparam int HALF_W        = WORD_W / 2;
    localparam int ACC_W         = 2 * WORD_W;
    localparam int WORD_SH       = $clog2(WORD_W);
    localparam int BITS_W        = 7;
    localparam int TOTAL_W       = 17;
    localparam int TOTAL_MAX     = 131071;
    localparam int DEF_MAX_WORDS = 1024;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] digit_value;
        logic [WORD_W-1:0] value_count;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]  packed_word;
        logic [BITS_W-1:0]  word_bits;
        logic               last_word;
        logic [TOTAL_W-1:0] total_bits;
        logic               range_error;
    } t_rsp;

    // status from the bit length unit
    typedef struct packed {
        logic              done;
        logic [BITS_W-1:0] len;
    } t_bl_stat;

endpackage

// ===== rtl/core/mrwp_mul.sv =====
// Shared 32x32 multiplier with a registered product.
module mrwp_mul import mrwp_pkg::*; (
    input  logic                i_clk,
    input  logic [HALF_W-1:0]   i_a,
    input  logic [HALF_W-1:0]   i_b,
    output logic [WORD_W-1:0]   o_p
);

    logic [WORD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= WORD_W'(i_a) * WORD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/mrwp_bitlen.sv =====
// Iterative bit length of (scale - 1): one right shift per cycle.
module mrwp_bitlen import mrwp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_scale,
    output t_bl_stat          o_stat
);

    logic              r_run;
    logic [WORD_W-1:0] r_x;
    logic [BITS_W-1:0] r_n;
    logic              w_done;

    assign w_done = r_run && (r_x == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (w_done) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_scale - WORD_W'(1);
            r_n <= '0;
        end else if (r_run && !w_done) begin
            r_x <= r_x >> 1;
            r_n <= r_n + BITS_W'(1);
        end
    end

    assign o_stat.done = w_done;
    assign o_stat.len  = r_n;

endmodule

// ===== rtl/core/mixed_radix_word_packer.sv =====
// Top level of the mixed radix word packer: sequencer and datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------
//  input   | in        | i_in_valid / o_in_stall  | i_in_data  (t_req)
//  output  | out       | o_out_valid / i_out_stall| o_out_data (t_rsp)
//
// A write that stays in the open word runs from the accept through the range
// check, scale*radix as four 32x32 partial products through the one shared
// multiplier, a decision state, scale*digit and a store state. A write that
// completes the word goes on from the store state to emit; one that spills the
// open word goes from the decision state to emit; a rejected write goes from
// the range check to emit. A flush waits on the bit length shifter, which
// takes one shift per used bit of the open word (up to 64).
// Reset clears the open word to 0, scale to 1, word count to 0, and empties
// the output register. A stalled result waits in the output register while
// the next transaction is already taken in; a second result waits in the
// sequencer (input stalled) until the output register frees up.
module mixed_radix_word_packer import mrwp_pkg::*; #(
    parameter int MAX_WORDS = DEF_MAX_WORDS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    localparam int WC_W  = $clog2(MAX_WORDS + 1);
    localparam int SUM_W = (WC_W + WORD_SH + 1 > TOTAL_W) ? WC_W + WORD_SH + 1 : TOTAL_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_MULR  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_MULD  = 4'd4;
    localparam logic [3:0] S_POST  = 4'd5;
    localparam logic [3:0] S_FLUSH = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [3:0]        r_state, n_state;
    logic [2:0]        r_step,  n_step;
    t_req              r_req,   n_req;
    logic [WORD_W-1:0] r_digit, n_digit;
    logic [WORD_W-1:0] r_radix, n_radix;
    logic [ACC_W-1:0]  r_acc,   n_acc;
    logic [WORD_W-1:0] r_new_scale, n_new_scale;
    logic              r_exact, n_exact;
    logic [WORD_W-1:0] r_word,  n_word;
    logic [WORD_W-1:0] r_scale, n_scale;
    logic [WC_W-1:0]   r_words, n_words;
    t_rsp              r_rsp,   n_rsp;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [HALF_W-1:0] w_mul_a, w_mul_b;
    logic [WORD_W-1:0] w_mul_b_src;
    logic [WORD_W-1:0] w_mul_p;
    logic [1:0]        w_term_idx;
    logic [ACC_W-1:0]  w_term;
    logic [ACC_W-1:0]  w_acc_sum;
    logic [WC_W-1:0]   w_words_inc;
    logic [SUM_W-1:0]  w_total;
    logic [TOTAL_W-1:0] w_total_sat;
    logic              w_out_free;
    logic              w_bl_start;
    t_bl_stat          w_bl;

    // partial product k: a half = k[1], b half = k[0]
    assign w_mul_b_src = (r_state == S_MULD) ? r_digit : r_radix;
    assign w_mul_a = r_step[1] ? r_scale[WORD_W-1:HALF_W] : r_scale[HALF_W-1:0];
    assign w_mul_b = r_step[0] ? w_mul_b_src[WORD_W-1:HALF_W] : w_mul_b_src[HALF_W-1:0];

    mrwp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // product registered last cycle belongs to step - 1
    assign w_term_idx = r_step[1:0] - 2'd1;

    always_comb begin
        case (w_term_idx)
            2'd0:    w_term = ACC_W'(w_mul_p);
            2'd3:    w_term = ACC_W'(w_mul_p) << (2 * HALF_W);
            default: w_term = ACC_W'(w_mul_p) << HALF_W;
        endcase
    end

    assign w_acc_sum = r_acc + w_term;

    // word count saturates at MAX_WORDS
    assign w_words_inc = (r_words != WC_W'(MAX_WORDS)) ? r_words + WC_W'(1) : r_words;

    assign w_total = SUM_W'({r_words, {WORD_SH{1'b0}}}) + SUM_W'(w_bl.len);
    assign w_total_sat = (w_total > SUM_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                       : TOTAL_W'(w_total);

    assign w_bl_start = (r_state == S_CHECK) && (r_req.req_type == REQ_FLUSH);

    mrwp_bitlen u_bitlen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bl_start),
        .i_scale (r_scale),
        .o_stat  (w_bl)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_req       = r_req;
        n_digit     = r_digit;
        n_radix     = r_radix;
        n_acc       = r_acc;
        n_new_scale = r_new_scale;
        n_exact     = r_exact;
        n_word      = r_word;
        n_scale     = r_scale;
        n_words     = r_words;
        n_rsp       = r_rsp;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_req.req_type == REQ_FLUSH) begin
                    n_state = S_FLUSH;
                end else if ((r_req.digit_value >= r_req.value_count) ||
                             (r_req.value_count == '1)) begin
                    // rejected value: error flag only, state untouched
                    n_rsp             = '0;
                    n_rsp.range_error = 1'b1;
                    n_state           = S_EMIT;
                end else begin
                    n_digit = r_req.digit_value + WORD_W'(1);
                    n_radix = r_req.value_count + WORD_W'(1);
                    n_acc   = '0;
                    n_step  = '0;
                    n_state = S_MULR;
                end
            end
            S_MULR, S_MULD: begin
                n_step = r_step + 3'd1;
                if (r_step != '0) begin
                    n_acc = w_acc_sum;
                end
                if (r_step == LAST_STEP) begin
                    n_state = (r_state == S_MULR) ? S_DEC : S_POST;
                end
            end
            S_DEC: begin
                if (r_acc[ACC_W-1:WORD_W] == '0) begin
                    // fits: digit joins the word, scale grows
                    n_new_scale = r_acc[WORD_W-1:0];
                    n_exact     = 1'b0;
                    n_acc       = ACC_W'(r_word);
                    n_step      = '0;
                    n_state     = S_MULD;
                end else if ((r_acc[ACC_W-1:WORD_W] == WORD_W'(1)) &&
                             (r_acc[WORD_W-1:0] == '0)) begin
                    // exactly full: digit completes the word
                    n_exact = 1'b1;
                    n_acc   = ACC_W'(r_word);
                    n_step  = '0;
                    n_state = S_MULD;
                end else begin
                    // overflow: ship the open word, digit opens a new one
                    n_rsp             = '0;
                    n_rsp.packed_word = r_word;
                    n_rsp.word_bits   = BITS_W'(WORD_W);
                    n_word            = r_digit;
                    n_scale           = r_radix;
                    n_words           = w_words_inc;
                    n_state           = S_EMIT;
                end
            end
            S_POST: begin
                if (r_exact) begin
                    n_rsp             = '0;
                    n_rsp.packed_word = r_acc[WORD_W-1:0];
                    n_rsp.word_bits   = BITS_W'(WORD_W);
                    n_word            = '0;
                    n_scale           = WORD_W'(1);
                    n_words           = w_words_inc;
                    n_state           = S_EMIT;
                end else begin
                    n_word  = r_acc[WORD_W-1:0];
                    n_scale = r_new_scale;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_bl.done) begin
                    n_rsp.packed_word = r_word;
                    n_rsp.word_bits   = w_bl.len;
                    n_rsp.last_word   = 1'b1;
                    n_rsp.total_bits  = w_total_sat;
                    n_rsp.range_error = 1'b0;
                    n_word            = '0;
                    n_scale           = WORD_W'(1);
                    n_words           = '0;
                    n_state           = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_word  <= '0;
            r_scale <= WORD_W'(1);
            r_words <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_scale <= n_scale;
            r_words <= n_words;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_req       <= n_req;
        r_digit     <= n_digit;
        r_radix     <= n_radix;
        r_acc       <= n_acc;
        r_new_scale <= n_new_scale;
        r_exact     <= n_exact;
        r_rsp       <= n_rsp;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out <= r_rsp;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/mrwp_chk.sv =====
// Port-level checker for the mixed radix word packer, bound to the top level.
module mrwp_chk import mrwp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_rsp o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // the input is stalled after every accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on back-to-back cycles");

    // a rejected value carries nothing but the flag
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.range_error |->
            (o_out_data.packed_word == '0) && (o_out_data.word_bits == '0) &&
            !o_out_data.last_word && (o_out_data.total_bits == '0))
        else $error("error result with payload");

    // a completed word is full and has no total
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.range_error && !o_out_data.last_word |->
            (o_out_data.word_bits == BITS_W'(WORD_W)) && (o_out_data.total_bits == '0))
        else $error("completed word not full");

    // a final word never claims more bits than a word
    a_last_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last_word |->
            (o_out_data.word_bits <= BITS_W'(WORD_W)) &&
            (TOTAL_W'(o_out_data.word_bits) <= o_out_data.total_bits))
        else $error("final word bit count out of range");

endmodule

bind mixed_radix_word_packer mrwp_chk u_mrwp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
